// ===== hw/rtl/dsw_pkg.sv =====
package dsw_pkg;

  localparam int unsigned SEQ_W = 32;

  // Empty ring slots read as all ones
  localparam logic [SEQ_W-1:0] EMPTY_SEQ = {SEQ_W{1'b1}};

  typedef enum logic {
    FUNC_CHECK  = 1'b0,
    FUNC_RECORD = 1'b1
  } func_e;

  typedef logic [SEQ_W-1:0] seq_t;

endpackage

// ===== hw/rtl/duplicate_sequence_window.sv =====
// Duplicate filter for one flooding source. A check transfer (func_i = 0) answers in
// is_new_o whether seq_number_i is new; a record transfer (func_i = 1) stores the number
// in a ring of the last DEPTH numbers unless it is below the window minimum, and reports
// that in stored_o. Every transfer returns exactly one result that also carries the
// window minimum and maximum after the item. The ring lives in a single-port-write,
// registered-read memory that one compare unit walks one entry per cycle, so an item
// that needs the ring (a check inside the window, or any stored record) passes through
// the EVAL, SCAN and FINISH states before the next transfer can be taken; a check
// above the maximum or below the minimum and a record below the minimum skip SCAN. A
// finished result waits in the output register while the next item is taken, and at
// most one item is in flight.
module duplicate_sequence_window #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                func_i,
  input  logic [dsw_pkg::SEQ_W-1:0] seq_number_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                is_new_o,
  output logic                stored_o,
  output logic [dsw_pkg::SEQ_W-1:0] window_min_o,
  output logic [dsw_pkg::SEQ_W-1:0] window_max_o
);
  import dsw_pkg::*;

  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_DEPTH = CNT_W'(DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_SCAN,
    ST_FINISH
  } state_e;

  state_e           state_q, state_d;
  logic             func_q;
  seq_t             seq_q;
  seq_t             highest_q, highest_d;
  seq_t             lowest_q, lowest_d;
  logic [IDX_W-1:0] ptr_q, ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             pend_q;
  logic             hit_q, hit_d;
  seq_t             min_acc_q, min_acc_d;
  logic             res_new_q, res_new_d;
  logic             res_stored_q, res_stored_d;
  logic             out_valid_q, out_valid_d;
  logic             is_new_q, stored_q;
  seq_t             win_min_q, win_max_q;
  logic             load_out;

  logic [DEPTH-1:0] vld_q;
  seq_t             mem [DEPTH];
  seq_t             rd_data_q;
  logic             rd_vld_q;
  logic [IDX_W-1:0] rd_addr;
  logic             issue;
  logic             mem_we;
  seq_t             entry;
  logic             in_xfer;

  assign in_xfer  = in_valid_i && (state_q == ST_IDLE);
  assign issue    = (state_q == ST_SCAN) && (cnt_q != CNT_DEPTH);
  assign rd_addr  = cnt_q[IDX_W-1:0];
  assign mem_we   = (state_q == ST_EVAL) && (func_q == FUNC_RECORD) && !(seq_q < lowest_q);
  assign entry    = rd_vld_q ? rd_data_q : EMPTY_SEQ;
  assign load_out = (state_q == ST_FINISH) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d      = state_q;
    highest_d    = highest_q;
    lowest_d     = lowest_q;
    ptr_d        = ptr_q;
    cnt_d        = cnt_q;
    hit_d        = hit_q;
    min_acc_d    = min_acc_q;
    res_new_d    = res_new_q;
    res_stored_d = res_stored_q;
    out_valid_d  = out_valid_q && out_stall_i;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cnt_d     = '0;
        hit_d     = 1'b0;
        min_acc_d = EMPTY_SEQ;
        if (func_q == FUNC_CHECK) begin
          res_stored_d = 1'b0;
          if (seq_q > highest_q) begin
            res_new_d = 1'b1;
            state_d   = ST_FINISH;
          end else if (seq_q < lowest_q) begin
            res_new_d = 1'b0;
            state_d   = ST_FINISH;
          end else begin
            state_d = ST_SCAN;
          end
        end else begin
          res_new_d = 1'b0;
          if (!mem_we) begin
            res_stored_d = 1'b0;
            state_d      = ST_FINISH;
          end else begin
            res_stored_d = 1'b1;
            if (seq_q > highest_q) begin
              highest_d = seq_q;
            end
            ptr_d   = (ptr_q == LAST_IDX) ? '0 : ptr_q + 1'b1;
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (issue) begin
          cnt_d = cnt_q + 1'b1;
        end
        if (pend_q) begin
          if (entry == seq_q) begin
            hit_d = 1'b1;
          end
          if (entry < min_acc_q) begin
            min_acc_d = entry;
          end
        end
        if (!issue && !pend_q) begin
          if (func_q == FUNC_RECORD) begin
            lowest_d = min_acc_q;
          end else begin
            res_new_d = !hit_q;
          end
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (load_out) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      highest_q    <= '0;
      lowest_q     <= '0;
      ptr_q        <= '0;
      cnt_q        <= '0;
      pend_q       <= 1'b0;
      hit_q        <= 1'b0;
      min_acc_q    <= EMPTY_SEQ;
      res_new_q    <= 1'b0;
      res_stored_q <= 1'b0;
      out_valid_q  <= 1'b0;
      vld_q        <= '0;
    end else begin
      state_q      <= state_d;
      highest_q    <= highest_d;
      lowest_q     <= lowest_d;
      ptr_q        <= ptr_d;
      cnt_q        <= cnt_d;
      pend_q       <= issue;
      hit_q        <= hit_d;
      min_acc_q    <= min_acc_d;
      res_new_q    <= res_new_d;
      res_stored_q <= res_stored_d;
      out_valid_q  <= out_valid_d;
      if (mem_we) begin
        vld_q[ptr_q] <= 1'b1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      func_q <= func_i;
      seq_q  <= seq_number_i;
    end
    if (load_out) begin
      is_new_q  <= res_new_q;
      stored_q  <= res_stored_q;
      win_min_q <= lowest_q;
      win_max_q <= highest_q;
    end
  end

  // Ring memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[ptr_q] <= seq_q;
    end
    rd_data_q <= mem[rd_addr];
    rd_vld_q  <= vld_q[rd_addr];
  end

  assign in_stall_o   = (state_q != ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign is_new_o     = is_new_q;
  assign stored_o     = stored_q;
  assign window_min_o = win_min_q;
  assign window_max_o = win_max_q;

  // The ring minimum never exceeds the highest number seen
  a_min_le_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (lowest_q <= highest_q))
    else $error("window minimum above maximum");

  a_one_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(is_new_o && stored_o))
    else $error("result flags both set");

  a_check_keeps_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_EVAL) && (func_q == FUNC_CHECK)) |=> $stable(ptr_q))
    else $error("check item moved the write pointer");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_DEPTH)
    else $error("scan counter past ring depth");

  a_write_stored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |=> (res_stored_q && (state_q == ST_SCAN)))
    else $error("ring write without stored result");

endmodule

// ===== tb/sv/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dsw_pkg::*;

  localparam int unsigned RING_DEPTH   = 16;
  localparam int unsigned IDLE_PCT     = 16;
  localparam int unsigned HOLD_CYCLES  = 200;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned DRAIN_CYCLES = RING_DEPTH + 12;

  typedef struct packed {
    logic is_new;
    logic stored;
    seq_t wmin;
    seq_t wmax;
  } verdict_t;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  logic func_i;
  seq_t seq_number_i;
  logic out_valid_o;
  logic out_stall_i;
  logic is_new_o;
  logic stored_o;
  seq_t window_min_o;
  seq_t window_max_o;

  duplicate_sequence_window #(
    .DEPTH(RING_DEPTH)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .func_i       (func_i),
    .seq_number_i (seq_number_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .is_new_o     (is_new_o),
    .stored_o     (stored_o),
    .window_min_o (window_min_o),
    .window_max_o (window_max_o)
  );

  // Predicted window state
  seq_t        ring_seqs [RING_DEPTH];
  seq_t        seen_max;
  seq_t        held_min;
  int unsigned next_slot;

  verdict_t    pending_verdicts [$];
  verdict_t    oldest;
  int unsigned mismatches;
  bit          idle_on;
  bit          hold_req;
  int unsigned hold_left;

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  function automatic verdict_t window_verdict(input func_e f, input seq_t s);
    verdict_t v;
    seq_t     m;
    v = '0;
    if (f == FUNC_CHECK) begin
      if (s > seen_max) begin
        v.is_new = 1'b1;
      end else if (s >= held_min) begin
        v.is_new = 1'b1;
        for (int k = 0; k < RING_DEPTH; k++) begin
          if (ring_seqs[k] == s) v.is_new = 1'b0;
        end
      end
    end else if (s >= held_min) begin
      v.stored = 1'b1;
      if (s > seen_max) seen_max = s;
      ring_seqs[next_slot] = s;
      next_slot = (next_slot + 1) % RING_DEPTH;
      m = EMPTY_SEQ;
      for (int k = 0; k < RING_DEPTH; k++) begin
        if (ring_seqs[k] < m) m = ring_seqs[k];
      end
      held_min = m;
    end
    v.wmin = held_min;
    v.wmax = seen_max;
    return v;
  endfunction

  function automatic seq_t below_max(input int unsigned k);
    return (seen_max >= k) ? seen_max - k : '0;
  endfunction

  // Offer one item, hold it until the transfer, then predict its result
  task automatic offer_seq(input func_e f, input seq_t s, output logic took_effect);
    verdict_t v;
    while (idle_on && ($urandom_range(99) < IDLE_PCT)) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    func_i       <= f;
    seq_number_i <= s;
    do @(posedge clk_i); while (in_stall_o);
    v = window_verdict(f, s);
    pending_verdicts.push_back(v);
    took_effect = (f == FUNC_CHECK) || v.stored;
  endtask

  // Result side: check each transfer, then pick the next stall
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("unexpected result: is_new=%0b stored=%0b min=%h max=%h",
                   is_new_o, stored_o, window_min_o, window_max_o);
        end
      end else begin
        oldest = pending_verdicts.pop_front();
        if (is_new_o !== oldest.is_new || stored_o !== oldest.stored ||
            window_min_o !== oldest.wmin || window_max_o !== oldest.wmax) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("mismatch: is_new %0b/%0b stored %0b/%0b min %h/%h max %h/%h (exp/got)",
                     oldest.is_new, is_new_o, oldest.stored, stored_o,
                     oldest.wmin, window_min_o, oldest.wmax, window_max_o);
          end
        end
      end
    end
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= idle_on && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // Empty window, minimum equal to a record, ignored record, pointer wrap
  task automatic test_first_records();
    logic hit;
    offer_seq(FUNC_CHECK,  32'd0,   hit);
    offer_seq(FUNC_CHECK,  32'd5,   hit);
    offer_seq(FUNC_RECORD, 32'd100, hit);
    offer_seq(FUNC_CHECK,  32'd100, hit);
    offer_seq(FUNC_CHECK,  32'd99,  hit);
    offer_seq(FUNC_CHECK,  32'd101, hit);
    offer_seq(FUNC_RECORD, 32'd100, hit);
    offer_seq(FUNC_RECORD, 32'd50,  hit);
    for (int unsigned n = 101; n <= 116; n++) offer_seq(FUNC_RECORD, n, hit);
    offer_seq(FUNC_CHECK, 32'd102, hit);
    offer_seq(FUNC_CHECK, 32'd100, hit);
    offer_seq(FUNC_CHECK, 32'h7fff_ffff, hit);
  endtask

  // Stall the result side for a long stretch while items keep coming
  task automatic test_backpressure();
    logic hit;
    hold_req = 1'b1;
    for (int n = 0; n < 12; n++) begin
      offer_seq(FUNC_RECORD, seen_max + $urandom_range(1, 3), hit);
    end
  endtask

  // Mostly in-order traffic around the window, with reorder, jumps and noise
  task automatic test_random_traffic(input int unsigned target);
    int unsigned effective;
    int unsigned pick;
    func_e       f;
    seq_t        s;
    logic        hit;
    effective = 0;
    while (effective < target) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        f = FUNC_RECORD;
        s = seen_max + $urandom_range(1, 3);
      end else if (pick < 55) begin
        f = FUNC_RECORD;
        s = below_max($urandom_range(0, 20));
      end else if (pick < 85) begin
        f = FUNC_CHECK;
        s = below_max($urandom_range(0, 24)) + $urandom_range(0, 4);
      end else if (pick < 95) begin
        f = FUNC_CHECK;
        s = $urandom;
      end else begin
        f = FUNC_RECORD;
        s = seen_max + $urandom_range(17, 5000);
      end
      offer_seq(f, s, hit);
      if (hit) effective++;
    end
  endtask

  task automatic test_quiet_stretch();
    idle_on = 1'b0;
    test_random_traffic(300);
    idle_on = 1'b1;
  endtask

  // All-ones number: raises the maximum to the top and matches the marker
  task automatic test_ceiling();
    logic hit;
    offer_seq(FUNC_CHECK,  EMPTY_SEQ,        hit);
    offer_seq(FUNC_RECORD, EMPTY_SEQ,        hit);
    offer_seq(FUNC_CHECK,  EMPTY_SEQ,        hit);
    offer_seq(FUNC_CHECK,  EMPTY_SEQ - 1'b1, hit);
    offer_seq(FUNC_CHECK,  32'd0,            hit);
    offer_seq(FUNC_RECORD, 32'd0,            hit);
    offer_seq(FUNC_RECORD, EMPTY_SEQ,        hit);
  endtask

  initial begin
    for (int k = 0; k < RING_DEPTH; k++) ring_seqs[k] = EMPTY_SEQ;
    seen_max     = '0;
    held_min     = '0;
    next_slot    = 0;
    mismatches   = 0;
    idle_on      = 1'b1;
    hold_req     = 1'b0;
    hold_left    = 0;
    rst_ni       <= 1'b0;
    in_valid_i   <= 1'b0;
    func_i       <= FUNC_CHECK;
    seq_number_i <= '0;
    out_stall_i  <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_first_records();
    test_backpressure();
    test_random_traffic(1300);
    test_quiet_stretch();
    test_ceiling();

    in_valid_i <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
